### sv/ffjl_pkg.sv
// ----------------------------------------------------------------------------
// ffjl_pkg
// Shared types and constants for the fault flag journal logger.
// ----------------------------------------------------------------------------
package ffjl_pkg;

   localparam int NUM_FLAGS     = 64;
   localparam int JOURNAL_DEPTH = 32;

   localparam int OPCODE_W  = 3;
   localparam int FINDEX_W  = 8;
   localparam int RINDEX_W  = 10;
   localparam int TIME_W    = 32;
   localparam int CODE_W    = 8;
   localparam int COUNT_W   = 9;

   localparam int FLAG_IDX_W = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;
   localparam int JRN_IDX_W  = $clog2(JOURNAL_DEPTH);

   localparam logic [FINDEX_W:0]   FLAG_LIMIT = (FINDEX_W+1)'(NUM_FLAGS);
   localparam logic [RINDEX_W:0]   JRN_LIMIT  = (RINDEX_W+1)'(JOURNAL_DEPTH);
   localparam logic [FLAG_IDX_W-1:0] LAST_FLAG = FLAG_IDX_W'(NUM_FLAGS - 1);
   localparam logic [JRN_IDX_W-1:0]  LAST_SLOT = JRN_IDX_W'(JOURNAL_DEPTH - 1);
   localparam logic [TIME_W-1:0]     TIME_ONES = {TIME_W{1'b1}};

   typedef enum logic [OPCODE_W-1:0] {
      OP_SET_FLAG   = 3'd0,
      OP_CLEAR_FLAG = 3'd1,
      OP_TEST_FLAG  = 3'd2,
      OP_SCAN       = 3'd3,
      OP_READ_REC   = 3'd4,
      OP_CLEAR_JRN  = 3'd5
   } op_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic flag_next;
      logic slot_start;
      logic slot_step;
      logic rec_write;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_scan;
      logic flag_new;
      logic flag_last;
      logic slot_done;
      logic out_free;
   } stat_type;

endpackage

### sv/ffjl_req_if.sv
// ----------------------------------------------------------------------------
// ffjl_req_if
// Request channel: opcode and operands with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffjl_req_if;
   import ffjl_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [FINDEX_W-1:0] flag_index;
   logic [RINDEX_W-1:0] record_index;
   logic [TIME_W-1:0]   now_seconds;

   modport source (output valid, opcode, flag_index, record_index, now_seconds,
                   input ready);
   modport sink   (input valid, opcode, flag_index, record_index, now_seconds,
                   output ready);
endinterface

### sv/ffjl_rsp_if.sv
// ----------------------------------------------------------------------------
// ffjl_rsp_if
// Response channel: one result per request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffjl_rsp_if;
   import ffjl_pkg::*;

   logic               valid;
   logic               ready;
   logic               status;
   logic               flag_value;
   logic [TIME_W-1:0]  record_time;
   logic [CODE_W-1:0]  record_code;
   logic [COUNT_W-1:0] logged_count;

   modport source (output valid, status, flag_value, record_time, record_code,
                   logged_count, input ready);
   modport sink   (input valid, status, flag_value, record_time, record_code,
                   logged_count, output ready);
endinterface

### sv/ffjl_dp.sv
// ----------------------------------------------------------------------------
// ffjl_dp
// Datapath: flag bitmap, snapshot, journal registers, scan counters and
// the response register.
// ----------------------------------------------------------------------------
module ffjl_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ffjl_pkg::cmd_type             cmd,
   output ffjl_pkg::stat_type            stat,
   input  logic [ffjl_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [ffjl_pkg::FINDEX_W-1:0] req_flag_index,
   input  logic [ffjl_pkg::RINDEX_W-1:0] req_record_index,
   input  logic [ffjl_pkg::TIME_W-1:0]   req_now_seconds,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_status,
   output logic                          rsp_flag_value,
   output logic [ffjl_pkg::TIME_W-1:0]   rsp_record_time,
   output logic [ffjl_pkg::CODE_W-1:0]   rsp_record_code,
   output logic [ffjl_pkg::COUNT_W-1:0]  rsp_logged_count
);
   import ffjl_pkg::*;

   logic [NUM_FLAGS-1:0]     flags_ff, flags_in;
   logic [NUM_FLAGS-1:0]     snap_ff, snap_in;
   logic [JOURNAL_DEPTH-1:0] jvalid_ff, jvalid_in;
   logic [TIME_W-1:0]        jtime_ff [JOURNAL_DEPTH];
   logic [CODE_W-1:0]        jcode_ff [JOURNAL_DEPTH];

   op_type                   op_ff;
   logic [FINDEX_W-1:0]      fi_ff;
   logic [RINDEX_W-1:0]      ri_ff;
   logic [TIME_W-1:0]        now_ff;

   logic [FLAG_IDX_W-1:0]    fidx_ff, fidx_in;
   logic [JRN_IDX_W-1:0]     slot_ff, slot_in;
   logic [JRN_IDX_W-1:0]     max_at_ff, max_at_in;
   logic [TIME_W-1:0]        max_ff, max_in;
   logic [JRN_IDX_W-1:0]     wslot_ff, wslot_in;
   logic [COUNT_W-1:0]       cnt_ff, cnt_in;

   logic                     rvalid_ff, rvalid_in;
   logic                     rstatus_ff, rstatus_in;
   logic                     rfval_ff, rfval_in;
   logic [TIME_W-1:0]        rtime_ff, rtime_in;
   logic [CODE_W-1:0]        rcode_ff, rcode_in;
   logic [COUNT_W-1:0]       rcount_ff, rcount_in;

   logic                     flag_ok, rec_ok;
   logic [FLAG_IDX_W-1:0]    fsel;
   logic [JRN_IDX_W-1:0]     rd_addr;
   logic [TIME_W-1:0]        rd_time;
   logic [CODE_W-1:0]        rd_code;
   logic                     slot_free;
   logic [JRN_IDX_W-1:0]     cand_at;

   assign flag_ok = {1'b0, fi_ff} < FLAG_LIMIT;
   assign rec_ok  = {1'b0, ri_ff} < JRN_LIMIT;
   assign fsel    = fi_ff[FLAG_IDX_W-1:0];

   // one journal read port, shared by the slot search and record reads
   assign rd_addr = cmd.finish ? ri_ff[JRN_IDX_W-1:0] : slot_ff;
   assign rd_time = jvalid_ff[rd_addr] ? jtime_ff[rd_addr] : '0;
   assign rd_code = jvalid_ff[rd_addr] ? jcode_ff[rd_addr] : '0;

   assign slot_free = (rd_time == '0) || (rd_time == TIME_ONES);
   assign cand_at   = (rd_time >= max_ff) ? slot_ff : max_at_ff;

   assign stat.is_scan   = (op_ff == OP_SCAN);
   assign stat.flag_new  = flags_ff[fidx_ff] && !snap_ff[fidx_ff];
   assign stat.flag_last = (fidx_ff == LAST_FLAG);
   assign stat.slot_done = slot_free || (slot_ff == LAST_SLOT);
   assign stat.out_free  = !rvalid_ff || rsp_ready;

   always_comb begin
      flags_in   = flags_ff;
      snap_in    = snap_ff;
      jvalid_in  = jvalid_ff;
      fidx_in    = fidx_ff;
      slot_in    = slot_ff;
      max_in     = max_ff;
      max_at_in  = max_at_ff;
      wslot_in   = wslot_ff;
      cnt_in     = cnt_ff;
      rvalid_in  = rvalid_ff && !rsp_ready;
      rstatus_in = rstatus_ff;
      rfval_in   = rfval_ff;
      rtime_in   = rtime_ff;
      rcode_in   = rcode_ff;
      rcount_in  = rcount_ff;

      if (cmd.scan_start) begin
         fidx_in = '0;
         cnt_in  = '0;
      end
      if (cmd.flag_next) begin
         fidx_in = fidx_ff + 1'b1;
      end
      if (cmd.slot_start) begin
         slot_in   = '0;
         max_in    = '0;
         max_at_in = '0;
      end
      if (cmd.slot_step) begin
         slot_in = slot_ff + 1'b1;
         if (rd_time >= max_ff) begin
            max_in    = rd_time;
            max_at_in = slot_ff;
         end
         if (slot_free) begin
            wslot_in = slot_ff;
         end else begin
            // full journal: slot after the newest, wrapping
            wslot_in = (cand_at == LAST_SLOT) ? '0 : cand_at + 1'b1;
         end
      end
      if (cmd.rec_write) begin
         jvalid_in[wslot_ff] = 1'b1;
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.finish) begin
         rvalid_in  = 1'b1;
         rstatus_in = 1'b0;
         rfval_in   = 1'b0;
         rtime_in   = '0;
         rcode_in   = '0;
         rcount_in  = '0;
         case (op_ff)
            OP_SET_FLAG: begin
               if (flag_ok) flags_in[fsel] = 1'b1;
               else rstatus_in = 1'b1;
            end
            OP_CLEAR_FLAG: begin
               if (flag_ok) flags_in[fsel] = 1'b0;
               else rstatus_in = 1'b1;
            end
            OP_TEST_FLAG: begin
               if (flag_ok) rfval_in = flags_ff[fsel];
               else rstatus_in = 1'b1;
            end
            OP_SCAN: begin
               snap_in   = flags_ff;
               rcount_in = cnt_ff;
            end
            OP_READ_REC: begin
               if (rec_ok) begin
                  rtime_in = rd_time;
                  rcode_in = rd_code;
               end else begin
                  rstatus_in = 1'b1;
               end
            end
            OP_CLEAR_JRN: begin
               jvalid_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff  <= '0;
         snap_ff   <= '0;
         jvalid_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         flags_ff  <= flags_in;
         snap_ff   <= snap_in;
         jvalid_ff <= jvalid_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_opcode);
         fi_ff  <= req_flag_index;
         ri_ff  <= req_record_index;
         now_ff <= req_now_seconds;
      end
      if (cmd.rec_write) begin
         jtime_ff[wslot_ff] <= now_ff;
         jcode_ff[wslot_ff] <= CODE_W'(fidx_ff);
      end
      fidx_ff    <= fidx_in;
      slot_ff    <= slot_in;
      max_ff     <= max_in;
      max_at_ff  <= max_at_in;
      wslot_ff   <= wslot_in;
      cnt_ff     <= cnt_in;
      rstatus_ff <= rstatus_in;
      rfval_ff   <= rfval_in;
      rtime_ff   <= rtime_in;
      rcode_ff   <= rcode_in;
      rcount_ff  <= rcount_in;
   end

   assign rsp_valid        = rvalid_ff;
   assign rsp_status       = rstatus_ff;
   assign rsp_flag_value   = rfval_ff;
   assign rsp_record_time  = rtime_ff;
   assign rsp_record_code  = rcode_ff;
   assign rsp_logged_count = rcount_ff;

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rec_write |=> jvalid_ff[$past(wslot_ff)])
      else $error("written journal slot not marked valid");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && op_ff == OP_CLEAR_JRN) |=> jvalid_ff == '0)
      else $error("journal not empty after clear");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> rcount_ff <= COUNT_W'(NUM_FLAGS))
      else $error("logged count beyond flag count");

endmodule

### sv/ffjl_ctrl.sv
// ----------------------------------------------------------------------------
// ffjl_ctrl
// Controller: sequences request decode, the flag scan with its slot search,
// and result hand-off.
// ----------------------------------------------------------------------------
module ffjl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ffjl_pkg::stat_type stat,
   output ffjl_pkg::cmd_type  cmd
);
   import ffjl_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_DECODE    = 6'b000010,
      ST_SCAN_FLAG = 6'b000100,
      ST_SCAN_SLOT = 6'b001000,
      ST_WRITE     = 6'b010000,
      ST_RESULT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load       = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = stat.is_scan ? ST_SCAN_FLAG : ST_RESULT;
         end
         ST_SCAN_FLAG: begin
            if (stat.flag_new) begin
               cmd.slot_start = 1'b1;
               state_in       = ST_SCAN_SLOT;
            end else if (stat.flag_last) begin
               state_in = ST_RESULT;
            end else begin
               cmd.flag_next = 1'b1;
            end
         end
         ST_SCAN_SLOT: begin
            cmd.slot_step = 1'b1;
            if (stat.slot_done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.rec_write = 1'b1;
            if (stat.flag_last) begin
               state_in = ST_RESULT;
            end else begin
               cmd.flag_next = 1'b1;
               state_in      = ST_SCAN_FLAG;
            end
         end
         ST_RESULT: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> stat.out_free)
      else $error("result register overwritten");

endmodule

### sv/fault_flag_journal_logger.sv
// ----------------------------------------------------------------------------
// fault_flag_journal_logger
// Fault flag bitmap with scan-time edge capture into a timestamped journal.
// ----------------------------------------------------------------------------
// Non-scan requests pass decode and result states; the result is registered
// once the response register is free. A scan visits every flag and, per new
//   flag, searches up to JOURNAL_DEPTH journal slots and writes one record.
// One request in flight; the next is taken once the result is registered.
// Reset clears flags, snapshot and journal valid bits at once, no sweep.
module fault_flag_journal_logger (
   input logic        clock,
   input logic        reset,
   ffjl_req_if.sink   req_chan,
   ffjl_rsp_if.source rsp_chan
);
   import ffjl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ffjl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffjl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_chan.opcode),
      .req_flag_index   (req_chan.flag_index),
      .req_record_index (req_chan.record_index),
      .req_now_seconds  (req_chan.now_seconds),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_status       (rsp_chan.status),
      .rsp_flag_value   (rsp_chan.flag_value),
      .rsp_record_time  (rsp_chan.record_time),
      .rsp_record_code  (rsp_chan.record_code),
      .rsp_logged_count (rsp_chan.logged_count)
   );

endmodule

### dv/tb_fault_flag_journal_logger.sv
// ----------------------------------------------------------------------------
// tb_fault_flag_journal_logger
// Drives random and directed fault-log requests in bursts, predicts every
// response from a behavioural copy of flags, snapshot and journal, and checks
// responses in order while the response side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_fault_flag_journal_logger;
   import ffjl_pkg::*;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [FINDEX_W-1:0] flag_index;
      logic [RINDEX_W-1:0] record_index;
      logic [TIME_W-1:0]   now_seconds;
   } req_type;

   typedef struct packed {
      logic               status;
      logic               flag_value;
      logic [TIME_W-1:0]  record_time;
      logic [CODE_W-1:0]  record_code;
      logic [COUNT_W-1:0] logged_count;
   } rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffjl_req_if req_chan ();
   ffjl_rsp_if rsp_chan ();

   fault_flag_journal_logger dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic              flags_now  [NUM_FLAGS];
   logic              flags_seen [NUM_FLAGS];
   logic [TIME_W-1:0] jrn_time   [JOURNAL_DEPTH];
   logic [CODE_W-1:0] jrn_code   [JOURNAL_DEPTH];

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      errors = 0;
   bit      stim_done = 1'b0;

   function automatic int free_slot();
      logic [TIME_W-1:0] newest;
      int                newest_at;
      newest = '0;
      newest_at = 0;
      for (int i = 0; i < JOURNAL_DEPTH; i++) begin
         if (jrn_time[i] == '0 || jrn_time[i] == TIME_ONES) return i;
         if (jrn_time[i] >= newest) begin
            newest = jrn_time[i];
            newest_at = i;
         end
      end
      return (newest_at + 1) % JOURNAL_DEPTH;
   endfunction

   function automatic rsp_type log_outcome(req_type r);
      rsp_type o;
      int      slot;
      bit      flag_ok;
      o = '0;
      flag_ok = r.flag_index < NUM_FLAGS;
      case (r.opcode)
         OP_SET_FLAG: begin
            if (flag_ok) flags_now[r.flag_index] = 1'b1; else o.status = 1'b1;
         end
         OP_CLEAR_FLAG: begin
            if (flag_ok) flags_now[r.flag_index] = 1'b0; else o.status = 1'b1;
         end
         OP_TEST_FLAG: begin
            if (flag_ok) o.flag_value = flags_now[r.flag_index]; else o.status = 1'b1;
         end
         OP_SCAN: begin
            for (int i = 0; i < NUM_FLAGS; i++) begin
               if (flags_now[i] && !flags_seen[i]) begin
                  slot = free_slot();
                  jrn_time[slot] = r.now_seconds;
                  jrn_code[slot] = CODE_W'(i);
                  o.logged_count++;
               end
            end
            for (int i = 0; i < NUM_FLAGS; i++) flags_seen[i] = flags_now[i];
         end
         OP_READ_REC: begin
            if (r.record_index < JOURNAL_DEPTH) begin
               o.record_time = jrn_time[r.record_index];
               o.record_code = jrn_code[r.record_index];
            end else begin
               o.status = 1'b1;
            end
         end
         OP_CLEAR_JRN: begin
            for (int i = 0; i < JOURNAL_DEPTH; i++) begin
               jrn_time[i] = '0;
               jrn_code[i] = '0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic void push_req(logic [OPCODE_W-1:0] op, int fi, int ri,
                                    logic [TIME_W-1:0] t);
      req_type r;
      r.opcode = op;
      r.flag_index = FINDEX_W'(fi);
      r.record_index = RINDEX_W'(ri);
      r.now_seconds = t;
      pending_reqs.push_back(r);
   endfunction

   // time stamps: mostly growing, sometimes zero, all ones or random
   function automatic logic [TIME_W-1:0] pick_stamp(ref logic [TIME_W-1:0] clk_s);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return TIME_ONES;
         2: return $urandom;
         default: begin
            clk_s += $urandom_range(1, 50);
            return clk_s;
         end
      endcase
   endfunction

   initial begin
      logic [TIME_W-1:0] clk_s;
      int                n;
      logic [OPCODE_W-1:0] op;
      for (int i = 0; i < NUM_FLAGS; i++) begin
         flags_now[i] = 1'b0;
         flags_seen[i] = 1'b0;
      end
      for (int i = 0; i < JOURNAL_DEPTH; i++) begin
         jrn_time[i] = '0;
         jrn_code[i] = '0;
      end
      // directed part
      push_req(OP_READ_REC, 0, 0, '0);
      push_req(OP_SET_FLAG, 0, 0, '0);
      push_req(OP_SET_FLAG, NUM_FLAGS - 1, 0, '0);
      push_req(OP_SET_FLAG, 255, 1023, TIME_ONES);
      push_req(OP_CLEAR_FLAG, NUM_FLAGS, 0, '0);
      push_req(OP_TEST_FLAG, 255, 0, '0);
      push_req(OP_TEST_FLAG, NUM_FLAGS - 1, 0, '0);
      push_req(OP_SCAN, 0, 0, 32'd100);
      push_req(OP_READ_REC, 0, 0, '0);
      push_req(OP_READ_REC, 1, 0, '0);
      push_req(OP_READ_REC, JOURNAL_DEPTH - 1, 0, '0);
      push_req(OP_READ_REC, JOURNAL_DEPTH, 0, '0);
      push_req(OP_READ_REC, 1023, 0, '0);
      push_req(OP_CLEAR_FLAG, 0, 0, '0);
      push_req(OP_TEST_FLAG, 0, 0, '0);
      push_req(OP_SET_FLAG, 0, 0, '0);
      push_req(OP_SCAN, 0, 0, '0);           // flag 0 cleared and set again between scans: nothing new
      push_req(OP_SET_FLAG, 5, 0, '0);
      push_req(OP_SCAN, 0, 0, TIME_ONES);    // all-ones stamp still written
      push_req(OP_READ_REC, 2, 0, '0);
      push_req(OP_SCAN, 0, 0, 32'd7);        // nothing new
      push_req(3'd6, 255, 1023, TIME_ONES);
      push_req(3'd7, 0, 0, '0);
      push_req(OP_CLEAR_JRN, 0, 0, '0);
      push_req(OP_READ_REC, 0, 0, '0);
      // random part: toggle flags then scan, so the ring fills and wraps
      clk_s = 32'd1000;
      n = 0;
      while (n < 1800) begin
         n++;
         case ($urandom_range(0, 99)) inside
            [0:34]:  op = OP_SET_FLAG;
            [35:54]: op = OP_CLEAR_FLAG;
            [55:64]: op = OP_TEST_FLAG;
            [65:79]: op = OP_SCAN;
            [80:94]: op = OP_READ_REC;
            [95:96]: op = OP_CLEAR_JRN;
            default: op = OPCODE_W'($urandom_range(6, 7));
         endcase
         push_req(op,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, NUM_FLAGS - 1),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, JOURNAL_DEPTH - 1),
                  pick_stamp(clk_s));
      end
      // one mass raise at the end to make a big scan
      for (int i = 0; i < NUM_FLAGS; i++) push_req(OP_SET_FLAG, i, 0, '0);
      push_req(OP_SCAN, 0, 0, $urandom);
      for (int i = 0; i < JOURNAL_DEPTH; i++) push_req(OP_READ_REC, i, 0, '0);
      stim_done = 1'b1;
   end

   // driver: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   bit req_fire = 1'b0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.opcode = '0;
      req_chan.flag_index = '0;
      req_chan.record_index = '0;
      req_chan.now_seconds = '0;
      rsp_chan.ready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // remember whether the transaction on the bus was taken at the rising edge
   always @(posedge clock) begin
      req_fire = req_chan.valid && req_chan.ready;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_chan.valid || req_fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_type r;
               r = pending_reqs.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.opcode <= r.opcode;
               req_chan.flag_index <= r.flag_index;
               req_chan.record_index <= r.record_index;
               req_chan.now_seconds <= r.now_seconds;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern: phases of full speed and of random stalling
   int stall_phase = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_phase == 0) stall_phase = $urandom_range(1, 300);
         stall_phase--;
         if (stall_phase > 150) rsp_chan.ready <= 1'b1;
         else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            req_type r;
            r.opcode = req_chan.opcode;
            r.flag_index = req_chan.flag_index;
            r.record_index = req_chan.record_index;
            r.now_seconds = req_chan.now_seconds;
            expected_rsps.push_back(log_outcome(r));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_type want;
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected response status=%0d", $time, rsp_chan.status);
            end else begin
               want = expected_rsps.pop_front();
               if (want.status !== rsp_chan.status)
                  $display("%0t: status exp %0d got %0d", $time, want.status, rsp_chan.status);
               if (want.flag_value !== rsp_chan.flag_value)
                  $display("%0t: flag_value exp %0d got %0d", $time, want.flag_value,
                           rsp_chan.flag_value);
               if (want.record_time !== rsp_chan.record_time)
                  $display("%0t: record_time exp %0h got %0h", $time, want.record_time,
                           rsp_chan.record_time);
               if (want.record_code !== rsp_chan.record_code)
                  $display("%0t: record_code exp %0d got %0d", $time, want.record_code,
                           rsp_chan.record_code);
               if (want.logged_count !== rsp_chan.logged_count)
                  $display("%0t: logged_count exp %0d got %0d", $time, want.logged_count,
                           rsp_chan.logged_count);
               if (want !== {rsp_chan.status, rsp_chan.flag_value, rsp_chan.record_time,
                             rsp_chan.record_code, rsp_chan.logged_count})
                  errors++;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      while (pending_reqs.size() > 0 || req_chan.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
sv/ffjl_pkg.sv
sv/ffjl_req_if.sv
sv/ffjl_rsp_if.sv
sv/ffjl_dp.sv
sv/ffjl_ctrl.sv
sv/fault_flag_journal_logger.sv
dv/tb_fault_flag_journal_logger.sv
